FILE: design/nwcs_pkg.sv
// ----------------------------------------------------------------------------
// nwcs_pkg
// Shared types and constants of the nearest wheel color select unit.
// ----------------------------------------------------------------------------
package nwcs_pkg;

    // Slot kinds as stored in the table. Any other code is never selected.
    localparam logic [1:0] KIND_OPEN  = 2'd0;
    localparam logic [1:0] KIND_COLOR = 2'd1;

    // Wanted color codes carried by a query.
    localparam logic [2:0] COLOR_OPEN    = 3'd0;
    localparam logic [2:0] COLOR_RED     = 3'd1;
    localparam logic [2:0] COLOR_CYAN    = 3'd2;
    localparam logic [2:0] COLOR_GREEN   = 3'd3;
    localparam logic [2:0] COLOR_BLUE    = 3'd4;
    localparam logic [2:0] COLOR_YELLOW  = 3'd5;
    localparam logic [2:0] COLOR_MAGENTA = 3'd6;
    localparam logic [2:0] COLOR_NONE    = 3'd7;

    // Input op selector on tuser.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Widths of the item buses.
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 8;
    localparam int DIST_W     = 18;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        logic write;     // store the accepted write item
        logic start;     // latch code and limit, clear the search
        logic issue;     // read the entry at the scan counter
        logic load_out;  // move the search result into the output register
    } nwcs_cmd_t;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic scan_end;  // every entry below the limit has been read
        logic pipe_busy; // reads are still on their way to the compare stage
        logic out_free;  // output register can take a result this cycle
    } nwcs_status_t;

    // Channel mask of the reference color: bit 2 red, bit 1 green, bit 0 blue.
    // A set bit means the channel is at full scale, a clear bit at zero.
    function automatic logic [2:0] ref_mask(input logic [2:0] code);
        logic [2:0] mask;
        begin
            case (code)
                COLOR_RED:     mask = 3'b100;
                COLOR_CYAN:    mask = 3'b011;
                COLOR_GREEN:   mask = 3'b010;
                COLOR_BLUE:    mask = 3'b001;
                COLOR_YELLOW:  mask = 3'b110;
                COLOR_MAGENTA: mask = 3'b101;
                default:       mask = 3'b000;
            endcase
            return mask;
        end
    endfunction

endpackage

FILE: design/nearest_wheel_color_select_unit.sv
// ----------------------------------------------------------------------------
// nearest_wheel_color_select_unit
// Color-wheel slot table with a first-open and nearest-color query.
// ----------------------------------------------------------------------------
// Items arrive on the s_ stream. With s_tuser low an item writes one table
// entry (kind and RGB color) and gives no result.
// With s_tuser high the item is a query for a wanted color code, and one
// result (found, chosen slot) leaves on the m_ stream.
// A query reads one table entry per cycle through the single read port of
// the slot table. Its result is offered once the scan has ended and the
// last read has passed the compare stage, and the next item is taken once
// the result sits in the output register.
// The slot_count register, written over APB at address 0, limits the
// entries searched.
// While the receiver stalls, writes are still taken and a further query is
// still accepted and scanned; its result then waits in the sequencer until
// the pending result has been transferred, and no item is taken meanwhile.
// Reset clears slot_count, the sequencer and the output valid flag; table
// contents are undefined until written.
// ----------------------------------------------------------------------------
module nearest_wheel_color_select_unit
#(
    parameter int MAX_SLOTS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata: slot_index[3:0], slot_kind[5:4], slot_red[13:6],
    // slot_green[21:14], slot_blue[29:22], wanted_color[32:30], zeros above
    input  logic [39:0] s_tdata,
    // s_tuser: op (0 write, 1 query)
    input  logic        s_tuser,
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata: found[0], chosen_slot[4:1], zeros above
    output logic [7:0]  m_tdata
);
    import nwcs_pkg::*;

    localparam logic REG_SLOT_COUNT = 1'b0;

    logic [4:0]   slot_count_reg;
    nwcs_cmd_t    cmd;
    nwcs_status_t status;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg <= 5'd0;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_SLOT_COUNT))
        begin
            slot_count_reg <= pwdata[4:0];
        end
    end

    assign prdata = (paddr[2] == REG_SLOT_COUNT) ? {27'd0, slot_count_reg} : 32'd0;

    nwcs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    nwcs_datapath #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .s_tdata    (s_tdata),
        .slot_count (slot_count_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

FILE: design/nwcs_ctrl.sv
// ----------------------------------------------------------------------------
// nwcs_ctrl
// Sequencer: accepts items, steps a query scan and hands off the result.
// ----------------------------------------------------------------------------
module nwcs_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tuser,
    output logic                  s_tready,
    input  nwcs_pkg::nwcs_status_t status,
    output nwcs_pkg::nwcs_cmd_t   cmd
);
    import nwcs_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cmd.write    = 1'b0;
        cmd.start    = 1'b0;
        cmd.issue    = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == OP_QUERY)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        cmd.write = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                if (status.scan_end)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cmd.issue = 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Hold the result until the output register has room.
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: design/nwcs_datapath.sv
// ----------------------------------------------------------------------------
// nwcs_datapath
// Slot table, scan counter, distance pipeline, best-match tracking and the
// output register.
// ----------------------------------------------------------------------------
module nwcs_datapath
#(
    parameter int MAX_SLOTS = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  nwcs_pkg::nwcs_cmd_t          cmd,
    output nwcs_pkg::nwcs_status_t       status,
    input  logic [nwcs_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic [4:0]                   slot_count,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [nwcs_pkg::OUT_DATA_W-1:0] m_tdata
);
    import nwcs_pkg::*;

    localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam logic [6:0] MAX7 = 7'(MAX_SLOTS);

    // Input field unpacking.
    logic [3:0] in_index;
    logic [1:0] in_kind;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [2:0] in_code;

    assign in_index = s_tdata[3:0];
    assign in_kind  = s_tdata[5:4];
    assign in_red   = s_tdata[13:6];
    assign in_green = s_tdata[21:14];
    assign in_blue  = s_tdata[29:22];
    assign in_code  = s_tdata[32:30];

    // Table word: kind in the top bits, then red, green, blue.
    logic [25:0] mem [MAX_SLOTS];

    logic [6:0]    idx7;
    logic          wr_ok;
    logic [AW-1:0] wr_addr;

    assign idx7    = 7'(in_index);
    assign wr_ok   = (idx7 < MAX7);
    assign wr_addr = idx7[AW-1:0];

    logic [6:0]    sc7;
    logic [6:0]    lim7;
    logic [CW-1:0] lim_reg;
    logic [CW-1:0] cnt_reg;
    logic [2:0]    code_reg;

    assign sc7  = 7'(slot_count);
    assign lim7 = (sc7 < MAX7) ? sc7 : MAX7;

    // Read stage.
    logic [25:0]   rd_reg;
    logic [AW-1:0] idx1_reg;
    logic          v1_reg;

    // Distance stage.
    logic [DIST_W-1:0] dist2_reg;
    logic [1:0]        kind2_reg;
    logic [AW-1:0]     idx2_reg;
    logic              v2_reg;

    // Search result.
    logic              found_reg;
    logic [DIST_W-1:0] best_reg;
    logic [AW-1:0]     chosen_reg;
    logic [6:0]        chosen7;

    assign chosen7 = 7'(chosen_reg);

    // Output register.
    logic       out_valid_reg;
    logic       out_found_reg;
    logic [3:0] out_slot_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.write && wr_ok)
        begin
            mem[wr_addr] <= {in_kind, in_red, in_green, in_blue};
        end
        if (cmd.issue)
        begin
            rd_reg <= mem[cnt_reg[AW-1:0]];
        end
    end

    // Distance to a reference channel of zero or full scale.
    logic [2:0]  mask;
    logic [7:0]  dr;
    logic [7:0]  dg;
    logic [7:0]  db;
    logic [15:0] sq_r;
    logic [15:0] sq_g;
    logic [15:0] sq_b;
    logic [DIST_W-1:0] dist_sum;

    assign mask = ref_mask(code_reg);
    assign dr   = mask[2] ? ~rd_reg[23:16] : rd_reg[23:16];
    assign dg   = mask[1] ? ~rd_reg[15:8]  : rd_reg[15:8];
    assign db   = mask[0] ? ~rd_reg[7:0]   : rd_reg[7:0];
    assign sq_r = 16'(dr) * 16'(dr);
    assign sq_g = 16'(dg) * 16'(dg);
    assign sq_b = 16'(db) * 16'(db);
    assign dist_sum = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);

    logic take;

    always_comb
    begin
        take = 1'b0;
        if (v2_reg)
        begin
            if (code_reg == COLOR_OPEN)
            begin
                take = (kind2_reg == KIND_OPEN) && !found_reg;
            end
            else if (code_reg inside {[COLOR_RED:COLOR_MAGENTA]})
            begin
                // Strict compare keeps the lower index on a tie.
                take = (kind2_reg == KIND_COLOR) && (!found_reg || (dist2_reg < best_reg));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            lim_reg  <= CW'(lim7);
            code_reg <= in_code;
        end
        if (cmd.issue)
        begin
            idx1_reg <= cnt_reg[AW-1:0];
        end
        dist2_reg <= dist_sum;
        kind2_reg <= rd_reg[25:24];
        idx2_reg  <= idx1_reg;
        if (take)
        begin
            best_reg   <= dist2_reg;
            chosen_reg <= idx2_reg;
        end
        if (cmd.load_out)
        begin
            out_found_reg <= found_reg;
            out_slot_reg  <= found_reg ? chosen7[3:0] : 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.issue)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            if (cmd.start)
            begin
                found_reg <= 1'b0;
            end
            else if (take)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.scan_end  = (cnt_reg >= lim_reg);
    assign status.pipe_busy = v1_reg || v2_reg;
    assign status.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_slot_reg, out_found_reg};

endmodule
